>>> rtl/text_console_writer_defines.svh
// text_console_writer_defines.svh: assertion macros for the text console rtl
// depends on nothing; expects clock and reset signals in the module that uses it
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// tcw_pkg: shared constants, codes and controller/datapath structs
// for the text console writer; no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // port widths fixed by the interface
   localparam int MODE_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int COL_PORT_W = 7;
   localparam int ROW_PORT_W = 5;
   localparam int LIN_PORT_W = 11;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT   = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_SET   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_NEWLINE,
      CUR_BACK,
      CUR_SET,
      CUR_HOME,
      CUR_BOTTOM
   } cur_op_type;

   typedef enum logic [1:0] {
      SWEEP_INIT,
      SWEEP_CLEAR,
      SWEEP_SCROLL
   } sweep_kind_type;

   typedef struct packed {
      logic           load_req;
      cur_op_type     cur_op;
      logic           wr_char;
      logic           wr_blank_back;
      logic           rd_cell;
      logic           sweep_start;
      sweep_kind_type sweep_kind;
      logic           set_scrolled;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     is_newline;
      logic     is_backspace;
      logic     at_last_col;
      logic     at_last_row;
      logic     sweep_done;
   } status_type;

endpackage

>>> rtl/text_console_writer.sv
// text_console_writer: character-cell text console, top level
// depends on tcw_pkg, tcw_ctrl and tcw_dp
//
//   port group   direction  handshake            content
//   req_*        in         start / busy         mode, char_code, col, row
//   rsp_*        out        rsp_valid, 1 cycle   cursor, linear, read cell, scrolled
//   csr_*        in         csr_wr_en            text attribute
//
// put, set cursor and read cell pass through exec and resp before the next accept.
// clear and scroll walk the cell store one cell a cycle, bounded by the single
// write port of the store.
// after reset a clearing pass over every cell holds busy high;
// csr writes are taken during it. the receiver cannot stall rsp_valid.
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [tcw_pkg::MODE_W-1:0]      req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::COL_PORT_W-1:0]  req_col,
   input  logic [tcw_pkg::ROW_PORT_W-1:0]  req_row,
   output logic                            rsp_valid,
   output logic [tcw_pkg::COL_PORT_W-1:0]  rsp_cursor_col,
   output logic [tcw_pkg::ROW_PORT_W-1:0]  rsp_cursor_row,
   output logic [tcw_pkg::LIN_PORT_W-1:0]  rsp_cursor_linear,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]      rsp_read_attr,
   output logic                            rsp_scrolled,
   input  logic                            csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0]      csr_wr_data
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_char_code     (req_char_code),
      .req_col           (req_col),
      .req_row           (req_row),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd_i             (cmd),
      .status_o          (status),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_linear (rsp_cursor_linear),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_attr     (rsp_read_attr),
      .rsp_scrolled      (rsp_scrolled)
   );

endmodule

>>> rtl/tcw_ctrl.sv
// tcw_ctrl: command sequencer for the text console writer
// depends on tcw_pkg and text_console_writer_defines.svh
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   input  tcw_pkg::status_type status_i,
   output tcw_pkg::cmd_type    cmd_o
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_INIT_WAIT,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in          = state_ff;
      cmd_o             = '0;
      cmd_o.cur_op      = tcw_pkg::CUR_HOLD;
      cmd_o.sweep_kind  = tcw_pkg::SWEEP_INIT;
      case (state_ff)
         ST_INIT: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = tcw_pkg::SWEEP_INIT;
            state_in          = ST_INIT_WAIT;
         end
         ST_INIT_WAIT: begin
            if (status_i.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_o.load_req = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            case (status_i.mode)
               tcw_pkg::MODE_PUT: begin
                  if (status_i.is_newline) begin
                     if (status_i.at_last_row) begin
                        cmd_o.sweep_start  = 1'b1;
                        cmd_o.sweep_kind   = tcw_pkg::SWEEP_SCROLL;
                        cmd_o.cur_op       = tcw_pkg::CUR_BOTTOM;
                        cmd_o.set_scrolled = 1'b1;
                        state_in           = ST_SWEEP;
                     end else begin
                        cmd_o.cur_op = tcw_pkg::CUR_NEWLINE;
                     end
                  end else if (status_i.is_backspace) begin
                     cmd_o.wr_blank_back = 1'b1;
                     cmd_o.cur_op        = tcw_pkg::CUR_BACK;
                  end else begin
                     cmd_o.wr_char = 1'b1;
                     // wrap off the last cell scrolls
                     if (status_i.at_last_col && status_i.at_last_row) begin
                        cmd_o.sweep_start  = 1'b1;
                        cmd_o.sweep_kind   = tcw_pkg::SWEEP_SCROLL;
                        cmd_o.cur_op       = tcw_pkg::CUR_BOTTOM;
                        cmd_o.set_scrolled = 1'b1;
                        state_in           = ST_SWEEP;
                     end else begin
                        cmd_o.cur_op = tcw_pkg::CUR_ADVANCE;
                     end
                  end
               end
               tcw_pkg::MODE_CLEAR: begin
                  cmd_o.sweep_start = 1'b1;
                  cmd_o.sweep_kind  = tcw_pkg::SWEEP_CLEAR;
                  cmd_o.cur_op      = tcw_pkg::CUR_HOME;
                  state_in          = ST_SWEEP;
               end
               tcw_pkg::MODE_SET: begin
                  cmd_o.cur_op = tcw_pkg::CUR_SET;
               end
               tcw_pkg::MODE_READ: begin
                  cmd_o.rd_cell = 1'b1;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SWEEP: begin
            if (status_i.sweep_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

   `TCW_ASSERT_NXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `TCW_ASSERT_NXT(a_accept_busy, accept, busy_ff, "not busy after accepting a word")
   `TCW_ASSERT_IMP(a_rsp_while_busy, rsp_valid_ff, busy_ff, "result strobe while idle")
   `TCW_ASSERT_IMP(a_sweep_done_state, status_i.sweep_done,
      (state_ff == ST_SWEEP) || (state_ff == ST_INIT_WAIT), "sweep ended outside a sweep wait")

endmodule

>>> rtl/tcw_dp.sv
// tcw_dp: cell store, cursor, attribute register and sweep engine
// of the text console writer; depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_dp #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tcw_pkg::MODE_W-1:0]      req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::COL_PORT_W-1:0]  req_col,
   input  logic [tcw_pkg::ROW_PORT_W-1:0]  req_row,
   input  logic                            csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0]      csr_wr_data,
   input  tcw_pkg::cmd_type                cmd_i,
   output tcw_pkg::status_type             status_o,
   output logic [tcw_pkg::COL_PORT_W-1:0]  rsp_cursor_col,
   output logic [tcw_pkg::ROW_PORT_W-1:0]  rsp_cursor_row,
   output logic [tcw_pkg::LIN_PORT_W-1:0]  rsp_cursor_linear,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]      rsp_read_attr,
   output logic                            rsp_scrolled
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CW     = tcw_pkg::CELL_W;

   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_CNT  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

   logic [CW-1:0] mem [CELLS];

   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   tcw_pkg::mode_type          mode_ff;
   logic [tcw_pkg::CHAR_W-1:0] char_ff;
   logic [COL_W-1:0]           col_sat_ff, col_sat_in;
   logic [ROW_W-1:0]           row_sat_ff, row_sat_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic                       scrolled_ff;
   logic                       read_sel_ff;
   logic [CW-1:0]              rd_data_ff;

   logic                       sweep_active_ff;
   tcw_pkg::sweep_kind_type    sweep_kind_ff;
   logic [ADDR_W-1:0]          sweep_idx_ff;
   logic                       pipe_valid_ff;
   logic                       pipe_copy_ff;
   logic [ADDR_W-1:0]          pipe_addr_ff;

   logic [ADDR_W-1:0] cur_lin, back_lin, req_lin;
   logic              sweep_copy;
   logic              we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [CW-1:0]     wdata, sweep_blank;

   // saturate the requested position
   always_comb begin
      if (int'(req_col) > COLUMNS - 1) begin
         col_sat_in = LAST_COL;
      end else begin
         col_sat_in = COL_W'(req_col);
      end
      if (int'(req_row) > ROWS - 1) begin
         row_sat_in = LAST_ROW;
      end else begin
         row_sat_in = ROW_W'(req_row);
      end
   end

   assign cur_lin  = ADDR_W'(row_ff) * ROW_STEP + ADDR_W'(col_ff);
   assign req_lin  = ADDR_W'(row_sat_ff) * ROW_STEP + ADDR_W'(col_sat_ff);
   assign back_lin = (cur_lin == '0) ? '0 : cur_lin - ADDR_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd_i.cur_op)
         tcw_pkg::CUR_ADVANCE: begin
            if (col_ff == LAST_COL) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         tcw_pkg::CUR_NEWLINE: begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end
         tcw_pkg::CUR_BACK: begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
            end else if (row_ff != '0) begin
               col_in = LAST_COL;
               row_in = row_ff - ROW_W'(1);
            end
         end
         tcw_pkg::CUR_SET: begin
            col_in = col_sat_ff;
            row_in = row_sat_ff;
         end
         tcw_pkg::CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         tcw_pkg::CUR_BOTTOM: begin
            col_in = '0;
            row_in = LAST_ROW;
         end
         default: begin
            col_in = col_ff;
            row_in = row_ff;
         end
      endcase
   end

   // scroll copies cell i + COLUMNS down to i; the write follows in the cycle after the read
   assign sweep_copy  = sweep_active_ff && (sweep_kind_ff == tcw_pkg::SWEEP_SCROLL)
                        && (sweep_idx_ff < COPY_CNT);
   assign sweep_blank = (sweep_kind_ff == tcw_pkg::SWEEP_INIT)
                        ? {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE}
                        : {attr_ff, tcw_pkg::CH_SPACE};

   always_comb begin
      we    = 1'b0;
      waddr = cur_lin;
      wdata = {attr_ff, char_ff};
      if (pipe_valid_ff) begin
         we    = 1'b1;
         waddr = pipe_addr_ff;
         wdata = pipe_copy_ff ? rd_data_ff : sweep_blank;
      end else if (cmd_i.wr_char) begin
         we    = 1'b1;
         waddr = cur_lin;
         wdata = {attr_ff, char_ff};
      end else if (cmd_i.wr_blank_back) begin
         we    = 1'b1;
         waddr = back_lin;
         wdata = {attr_ff, tcw_pkg::CH_SPACE};
      end
   end

   assign re    = sweep_copy || cmd_i.rd_cell;
   assign raddr = sweep_copy ? sweep_idx_ff + ROW_STEP : req_lin;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff         <= tcw_pkg::RESET_ATTR;
         col_ff          <= '0;
         row_ff          <= '0;
         scrolled_ff     <= 1'b0;
         read_sel_ff     <= 1'b0;
         sweep_active_ff <= 1'b0;
         sweep_kind_ff   <= tcw_pkg::SWEEP_INIT;
         sweep_idx_ff    <= '0;
         pipe_valid_ff   <= 1'b0;
         pipe_copy_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
         if (cmd_i.load_req) begin
            scrolled_ff <= 1'b0;
            read_sel_ff <= 1'b0;
         end else begin
            if (cmd_i.set_scrolled) begin
               scrolled_ff <= 1'b1;
            end
            if (cmd_i.rd_cell) begin
               read_sel_ff <= 1'b1;
            end
         end
         if (cmd_i.sweep_start) begin
            sweep_active_ff <= 1'b1;
            sweep_kind_ff   <= cmd_i.sweep_kind;
            sweep_idx_ff    <= '0;
         end else if (sweep_active_ff) begin
            sweep_idx_ff <= sweep_idx_ff + ADDR_W'(1);
            if (sweep_idx_ff == LAST_CELL) begin
               sweep_active_ff <= 1'b0;
            end
         end
         pipe_valid_ff <= sweep_active_ff;
         pipe_copy_ff  <= sweep_copy;
      end
   end

   always_ff @(posedge clock) begin
      pipe_addr_ff <= sweep_idx_ff;
      if (cmd_i.load_req) begin
         mode_ff    <= tcw_pkg::mode_type'(req_mode);
         char_ff    <= req_char_code;
         col_sat_ff <= col_sat_in;
         row_sat_ff <= row_sat_in;
      end
   end

   assign status_o.mode         = mode_ff;
   assign status_o.is_newline   = (char_ff == tcw_pkg::CH_NEWLINE);
   assign status_o.is_backspace = (char_ff == tcw_pkg::CH_BACKSPACE);
   assign status_o.at_last_col  = (col_ff == LAST_COL);
   assign status_o.at_last_row  = (row_ff == LAST_ROW);
   assign status_o.sweep_done   = pipe_valid_ff && (pipe_addr_ff == LAST_CELL);

   assign rsp_cursor_col    = tcw_pkg::COL_PORT_W'(col_ff);
   assign rsp_cursor_row    = tcw_pkg::ROW_PORT_W'(row_ff);
   assign rsp_cursor_linear = tcw_pkg::LIN_PORT_W'(cur_lin);
   assign rsp_read_char     = read_sel_ff ? rd_data_ff[tcw_pkg::CHAR_W-1:0] : '0;
   assign rsp_read_attr     = read_sel_ff ? rd_data_ff[CW-1:tcw_pkg::CHAR_W] : '0;
   assign rsp_scrolled      = scrolled_ff;

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for the text_console_writer character console
// drives commands on the start/busy port, predicts each result word in the bench or takes it
// from the directed table, and checks it against rsp_*; depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   localparam int COLS        = DEF_COLUMNS;
   localparam int LINES       = DEF_ROWS;
   localparam int CELLS       = COLS * LINES;
   localparam int STALL_LIMIT = 10000;
   localparam int PHASE_ITEMS = 200;

   typedef struct packed {
      mode_type                mode;
      logic [CHAR_W-1:0]       char_code;
      logic [COL_PORT_W-1:0]   col;
      logic [ROW_PORT_W-1:0]   row;
   } console_cmd_t;

   typedef struct packed {
      logic [COL_PORT_W-1:0]   cursor_col;
      logic [ROW_PORT_W-1:0]   cursor_row;
      logic [LIN_PORT_W-1:0]   cursor_linear;
      logic [CHAR_W-1:0]       read_char;
      logic [ATTR_W-1:0]       read_attr;
      logic                    scrolled;
   } console_result_t;

   typedef struct packed {
      console_cmd_t            cmd;
      logic                    typed;
      console_result_t         res;
   } directed_row_t;

   localparam logic            TYPED     = 1'b1;
   localparam logic            PREDICTED = 1'b0;
   localparam console_result_t NO_RES    = '0;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [MODE_W-1:0]       req_mode = '0;
   logic [CHAR_W-1:0]       req_char_code = '0;
   logic [COL_PORT_W-1:0]   req_col = '0;
   logic [ROW_PORT_W-1:0]   req_row = '0;
   logic                    rsp_valid;
   logic [COL_PORT_W-1:0]   rsp_cursor_col;
   logic [ROW_PORT_W-1:0]   rsp_cursor_row;
   logic [LIN_PORT_W-1:0]   rsp_cursor_linear;
   logic [CHAR_W-1:0]       rsp_read_char;
   logic [ATTR_W-1:0]       rsp_read_attr;
   logic                    rsp_scrolled;
   logic                    csr_wr_en = 1'b0;
   logic [ATTR_W-1:0]       csr_wr_data = '0;

   // bench copy of the console
   logic [CELL_W-1:0]       shadow_cells [CELLS];
   int                      shadow_col;
   int                      shadow_row;
   logic [ATTR_W-1:0]       shadow_attr;

   console_result_t         pending_results [$];
   int                      fail_count = 0;
   int                      mode_hits [4] = '{0, 0, 0, 0};
   int                      scroll_hits = 0;
   int                      attr_settings = 1;

   // cursor and cell results after reset, at the extremes and at wrap/scroll points
   directed_row_t directed_rows [22] = '{
      '{'{MODE_READ,  8'h00, 7'd0,   5'd0},  TYPED,
        '{7'd0,  5'd0,  11'd0,    CH_SPACE, RESET_ATTR, 1'b0}},
      '{'{MODE_READ,  8'hFF, 7'd127, 5'd31}, TYPED,
        '{7'd0,  5'd0,  11'd0,    CH_SPACE, RESET_ATTR, 1'b0}},
      '{'{MODE_PUT,   8'h41, 7'd0,   5'd0},  TYPED,
        '{7'd1,  5'd0,  11'd1,    8'h00, 8'h00, 1'b0}},
      '{'{MODE_PUT,   CH_BACKSPACE, 7'd0, 5'd0}, TYPED,
        '{7'd0,  5'd0,  11'd0,    8'h00, 8'h00, 1'b0}},
      '{'{MODE_PUT,   CH_BACKSPACE, 7'd0, 5'd0}, TYPED,
        '{7'd0,  5'd0,  11'd0,    8'h00, 8'h00, 1'b0}},
      '{'{MODE_READ,  8'h00, 7'd0,   5'd0},  TYPED,
        '{7'd0,  5'd0,  11'd0,    CH_SPACE, RESET_ATTR, 1'b0}},
      '{'{MODE_SET,   8'h00, 7'd127, 5'd31}, TYPED,
        '{7'd79, 5'd24, 11'd1999, 8'h00, 8'h00, 1'b0}},
      '{'{MODE_PUT,   8'hFF, 7'd0,   5'd0},  TYPED,
        '{7'd0,  5'd24, 11'd1920, 8'h00, 8'h00, 1'b1}},
      '{'{MODE_READ,  8'h00, 7'd79,  5'd23}, TYPED,
        '{7'd0,  5'd24, 11'd1920, 8'hFF, RESET_ATTR, 1'b0}},
      '{'{MODE_PUT,   CH_NEWLINE, 7'd0, 5'd0}, TYPED,
        '{7'd0,  5'd24, 11'd1920, 8'h00, 8'h00, 1'b1}},
      '{'{MODE_READ,  8'h00, 7'd79,  5'd22}, PREDICTED, NO_RES},
      '{'{MODE_SET,   8'h00, 7'd0,   5'd1},  TYPED,
        '{7'd0,  5'd1,  11'd80,   8'h00, 8'h00, 1'b0}},
      '{'{MODE_PUT,   CH_BACKSPACE, 7'd0, 5'd0}, TYPED,
        '{7'd79, 5'd0,  11'd79,   8'h00, 8'h00, 1'b0}},
      '{'{MODE_PUT,   8'h00, 7'd0,   5'd0},  TYPED,
        '{7'd0,  5'd1,  11'd80,   8'h00, 8'h00, 1'b0}},
      '{'{MODE_READ,  8'h55, 7'd79,  5'd0},  PREDICTED, NO_RES},
      '{'{MODE_SET,   8'h33, 7'd5,   5'd3},  PREDICTED, NO_RES},
      '{'{MODE_PUT,   CH_NEWLINE, 7'd64, 5'd16}, PREDICTED, NO_RES},
      '{'{MODE_PUT,   8'h7E, 7'd0,   5'd0},  PREDICTED, NO_RES},
      '{'{MODE_CLEAR, 8'hFF, 7'd127, 5'd31}, TYPED,
        '{7'd0,  5'd0,  11'd0,    8'h00, 8'h00, 1'b0}},
      '{'{MODE_READ,  8'h00, 7'd10,  5'd10}, TYPED,
        '{7'd0,  5'd0,  11'd0,    CH_SPACE, RESET_ATTR, 1'b0}},
      '{'{MODE_PUT,   8'h80, 7'd0,   5'd0},  PREDICTED, NO_RES},
      '{'{MODE_READ,  8'hAA, 7'd0,   5'd24}, PREDICTED, NO_RES}
   };

   text_console_writer uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_char_code     (req_char_code),
      .req_col           (req_col),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_linear (rsp_cursor_linear),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_attr     (rsp_read_attr),
      .rsp_scrolled      (rsp_scrolled),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // cursor to start of next row, scrolling past the bottom
   function automatic logic advance_line();
      shadow_col = 0;
      shadow_row++;
      if (shadow_row >= LINES) begin
         for (int i = 0; i < (LINES - 1) * COLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
         for (int i = (LINES - 1) * COLS; i < CELLS; i++)
            shadow_cells[i] = {shadow_attr, CH_SPACE};
         shadow_row = LINES - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic console_result_t apply_command(console_cmd_t cmd);
      console_result_t res;
      int c;
      int r;
      int lin;
      res = '0;
      c = (cmd.col > COLS - 1) ? COLS - 1 : int'(cmd.col);
      r = (cmd.row > LINES - 1) ? LINES - 1 : int'(cmd.row);
      case (cmd.mode)
         MODE_PUT: begin
            lin = shadow_row * COLS + shadow_col;
            if (cmd.char_code == CH_NEWLINE) begin
               res.scrolled = advance_line();
            end else if (cmd.char_code == CH_BACKSPACE) begin
               if (lin >= 1) lin--;
               shadow_row = lin / COLS;
               shadow_col = lin % COLS;
               shadow_cells[lin] = {shadow_attr, CH_SPACE};
            end else begin
               shadow_cells[lin] = {shadow_attr, cmd.char_code};
               shadow_col++;
               if (shadow_col >= COLS) res.scrolled = advance_line();
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               shadow_cells[i] = {shadow_attr, CH_SPACE};
            shadow_col = 0;
            shadow_row = 0;
         end
         MODE_SET: begin
            shadow_col = c;
            shadow_row = r;
         end
         default: begin
            {res.read_attr, res.read_char} = shadow_cells[r * COLS + c];
         end
      endcase
      res.cursor_col    = COL_PORT_W'(shadow_col);
      res.cursor_row    = ROW_PORT_W'(shadow_row);
      res.cursor_linear = LIN_PORT_W'(shadow_row * COLS + shadow_col);
      return res;
   endfunction

   function automatic string describe(console_result_t r);
      return $sformatf("col %0d row %0d lin %0d char %h attr %h scrolled %0d",
                       r.cursor_col, r.cursor_row, r.cursor_linear,
                       r.read_char, r.read_attr, r.scrolled);
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // start stays high when the next word follows at once
   task automatic issue_command(input console_cmd_t cmd, input logic typed,
                                input console_result_t typed_res, input bit idle_on);
      console_result_t predicted;
      int gap;
      req_mode      <= cmd.mode;
      req_char_code <= cmd.char_code;
      req_col       <= cmd.col;
      req_row       <= cmd.row;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = apply_command(cmd);
      pending_results.push_back(typed ? typed_res : predicted);
      mode_hits[cmd.mode]++;
      if (predicted.scrolled) scroll_hits++;
      gap = (idle_on && $urandom_range(0, 99) < 6) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_console_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin
      console_result_t got;
      console_result_t want;
      if (!reset && rsp_valid) begin
         got = '{rsp_cursor_col, rsp_cursor_row, rsp_cursor_linear,
                 rsp_read_char, rsp_read_attr, rsp_scrolled};
         if (pending_results.size() == 0) begin
            report_failure({"unexpected result word: ", describe(got)});
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               report_failure({"mismatch: expected ", describe(want),
                               " / got ", describe(got)});
         end
      end
   end

   // cycles with no word moving on either side
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) stall = 0;
         else stall++;
      end
      $display("stalled for %0d cycles with %0d results pending",
               STALL_LIMIT, pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      console_cmd_t cmd;
      logic [ATTR_W-1:0] attr_value;
      int sel;
      for (int i = 0; i < CELLS; i++) shadow_cells[i] = {RESET_ATTR, CH_SPACE};
      shadow_col  = 0;
      shadow_row  = 0;
      shadow_attr = RESET_ATTR;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // let the power-up clear finish
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      foreach (directed_rows[i])
         issue_command(directed_rows[i].cmd, directed_rows[i].typed,
                       directed_rows[i].res, 1'b1);

      for (int phase = 0; phase < 5; phase++) begin
         wait_console_idle();
         if (phase == 0) attr_value = 8'h00;
         else if (phase == 1) attr_value = 8'hFF;
         else attr_value = ATTR_W'($urandom_range(0, 255));
         csr_wr_data <= attr_value;
         csr_wr_en   <= 1'b1;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         shadow_attr = attr_value;
         attr_settings++;

         repeat (PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) cmd.mode = MODE_PUT;
            else if (sel < 68) cmd.mode = MODE_SET;
            else if (sel < 97) cmd.mode = MODE_READ;
            else cmd.mode = MODE_CLEAR;
            sel = $urandom_range(0, 99);
            if (sel < 15) cmd.char_code = CH_NEWLINE;
            else if (sel < 27) cmd.char_code = CH_BACKSPACE;
            else cmd.char_code = CHAR_W'($urandom_range(0, 255));
            // lean toward the right edge and bottom row to hit wraps and scrolls
            sel = $urandom_range(0, 99);
            if (sel < 10) cmd.col = COL_PORT_W'($urandom_range(COLS, 127));
            else if (sel < 35) cmd.col = COL_PORT_W'($urandom_range(COLS - 8, COLS - 1));
            else cmd.col = COL_PORT_W'($urandom_range(0, COLS - 1));
            sel = $urandom_range(0, 99);
            if (sel < 10) cmd.row = ROW_PORT_W'($urandom_range(LINES, 31));
            else if (sel < 40) cmd.row = ROW_PORT_W'(LINES - 1);
            else cmd.row = ROW_PORT_W'($urandom_range(0, LINES - 1));
            // phase 3 runs back to back with no sender idling
            issue_command(cmd, PREDICTED, NO_RES, phase != 3);
         end
      end

      wait_console_idle();
      repeat (CELLS + 8) @(posedge clock);

      $display("ran %0d puts, %0d clears, %0d cursor sets, %0d cell reads",
               mode_hits[MODE_PUT], mode_hits[MODE_CLEAR], mode_hits[MODE_SET],
               mode_hits[MODE_READ]);
      $display("%0d scrolls seen over %0d attribute settings, %0d failures",
               scroll_hits, attr_settings, fail_count);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_writer.sv
bench/tb_top.sv
